/* design/rlps_pkg.sv */
// ----------------------------------------------------------------------------
// rlps_pkg
// Shared types and constants of the LED chain pulse serializer: item and
// command layouts, configuration register codes and back-end state codes.
// ----------------------------------------------------------------------------
package rlps_pkg;

    // Bits sent for one LED, green byte first, MSB first.
    localparam int BITS_PER_LED = 24;
    localparam int WORD_W       = 24;

    // Command queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TOP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_SLOTS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEDS = 3'd4;
    localparam int CFG_DATA_W = 16;

    // Input item kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [5:0] led_index;
        logic [6:0] fill_count;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } in_item_t;

    typedef struct packed {
        logic line_level;
        logic frame_start;
    } out_item_t;

    typedef struct packed {
        logic [15:0] bit_top;
        logic [15:0] zero_high;
        logic [15:0] one_high;
        logic [9:0]  reset_slots;
        logic [6:0]  active_leds;
    } cfg_t;

    typedef enum logic {
        OP_WRITE,
        OP_TICK
    } op_t;

    // Classified command as it sits in the queue.
    typedef struct packed {
        op_t               op;
        logic [5:0]        first;
        logic [6:0]        count;
        logic [WORD_W-1:0] word;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_RUN,
        BK_FILL,
        BK_LOAD
    } back_state_t;

endpackage

/* design/rlps_front.sv */
// ----------------------------------------------------------------------------
// rlps_front
// Accepts input items, classifies them into write or tick commands, packs
// the color into the green-red-blue word and pushes them into the queue.
// ----------------------------------------------------------------------------
module rlps_front (
    input  logic              in_valid,
    output logic              in_stall,
    input  rlps_pkg::in_item_t in_data,
    input  logic              fifo_full,
    input  logic              clearing,
    output logic              push,
    output rlps_pkg::cmd_t    push_cmd
);
    import rlps_pkg::*;

    // Hold off requests while the frame store is cleared or the queue is full.
    assign in_stall = clearing | fifo_full;
    assign push     = in_valid & ~in_stall;

    // Decode the item kind and build the command.
    always_comb
    begin
        push_cmd.first = in_data.led_index;
        push_cmd.count = in_data.fill_count;
        push_cmd.word  = {in_data.green, in_data.red, in_data.blue};
        unique case (in_data.kind)
            KIND_WRITE: push_cmd.op = OP_WRITE;
            KIND_TICK:  push_cmd.op = OP_TICK;
            default:    push_cmd.op = OP_TICK;
        endcase
    end

endmodule

/* design/rlps_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// rlps_cmd_fifo
// Short command queue that decouples the accepting front from the back end.
// ----------------------------------------------------------------------------
module rlps_cmd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  rlps_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output rlps_pkg::cmd_t head
);
    import rlps_pkg::*;

    cmd_t           slot_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;
    logic           do_pop;

    assign full       = (count_reg == (QAW+1)'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_pop     = pop & head_valid;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* design/rlps_back.sv */
// ----------------------------------------------------------------------------
// rlps_back
// Executes queued commands: fills runs of the frame store and advances the
// bit timing for each tick, producing the line level into an output register.
// ----------------------------------------------------------------------------
module rlps_back #(
    parameter int LED_SLOTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rlps_pkg::cfg_t     cfg,
    input  logic               head_valid,
    input  rlps_pkg::cmd_t     head,
    output logic               pop,
    output logic               clearing,
    output logic               out_valid,
    input  logic               out_stall,
    output rlps_pkg::out_item_t out_data
);
    import rlps_pkg::*;

    localparam int AW = (LED_SLOTS > 1) ? $clog2(LED_SLOTS) : 1;

    logic [WORD_W-1:0] frame_mem [LED_SLOTS];

    back_state_t       state_reg, state_next;
    logic [AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [7:0]        fill_pos_reg, fill_pos_next;
    logic [6:0]        fill_left_reg, fill_left_next;
    logic [WORD_W-1:0] fill_word_reg, fill_word_next;
    logic [15:0]       tick_reg, tick_next;
    logic [4:0]        bitpos_reg, bitpos_next;
    logic [6:0]        ptr_reg, ptr_next;
    logic [9:0]        gap_reg, gap_next;
    logic              in_gap_reg, in_gap_next;
    logic [WORD_W-1:0] shift_reg, shift_next;
    logic [WORD_W-1:0] rd_data_reg;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_data_reg, out_data_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    logic              out_free;
    logic              need_load;
    logic              do_tick;
    logic [WORD_W-1:0] cur_word;
    logic [15:0]       high_ticks;
    logic [6:0]        leds;
    logic [10:0]       gap_sum;
    logic [4:0]        bit_sum;
    logic [7:0]        ptr_sum;

    assign clearing  = (state_reg == BK_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Command sequencing, store access and bit timing.
    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        fill_pos_next  = fill_pos_reg;
        fill_left_next = fill_left_reg;
        fill_word_next = fill_word_reg;
        tick_next      = tick_reg;
        bitpos_next    = bitpos_reg;
        ptr_next       = ptr_reg;
        gap_next       = gap_reg;
        in_gap_next    = in_gap_reg;
        shift_next     = shift_reg;
        out_data_next  = out_data_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = AW'(ptr_reg);
        do_tick        = 1'b0;
        gap_sum        = {1'b0, gap_reg} + 11'd1;
        bit_sum        = bitpos_reg + 5'd1;
        ptr_sum        = {1'b0, ptr_reg} + 8'd1;

        out_free       = !out_valid_reg || !out_stall;
        out_valid_next = out_valid_reg && out_stall;

        // LEDs per frame, clamped to at least one and to the store size.
        leds = (cfg.active_leds == 7'd0) ? 7'd1 : cfg.active_leds;
        if (32'(leds) > LED_SLOTS)
        begin
            leds = 7'(LED_SLOTS);
        end

        // The first tick of each LED needs its word from the store.
        need_load  = !in_gap_reg && (tick_reg == 16'd0) && (bitpos_reg == 5'd0);
        cur_word   = (state_reg == BK_LOAD) ? rd_data_reg : shift_reg;
        high_ticks = cur_word[BITS_PER_LED-1] ? cfg.one_high : cfg.zero_high;

        unique case (state_reg)
            BK_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                if (clr_addr_reg == AW'(LED_SLOTS - 1))
                begin
                    state_next = BK_RUN;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            BK_RUN:
            begin
                if (head_valid)
                begin
                    unique case (head.op)
                        OP_WRITE:
                        begin
                            pop = 1'b1;
                            if (head.count != 7'd0)
                            begin
                                if (32'(head.first) < LED_SLOTS)
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = AW'(head.first);
                                    wr_data = head.word;
                                end
                                fill_pos_next  = {2'b00, head.first} + 8'd1;
                                fill_left_next = head.count - 7'd1;
                                fill_word_next = head.word;
                                if (head.count != 7'd1)
                                begin
                                    state_next = BK_FILL;
                                end
                            end
                        end
                        OP_TICK:
                        begin
                            if (need_load)
                            begin
                                rd_en      = 1'b1;
                                state_next = BK_LOAD;
                            end
                            else if (out_free)
                            begin
                                do_tick = 1'b1;
                                pop     = 1'b1;
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_FILL:
            begin
                if (32'(fill_pos_reg) < LED_SLOTS)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(fill_pos_reg);
                    wr_data = fill_word_reg;
                end
                fill_pos_next  = fill_pos_reg + 8'd1;
                fill_left_next = fill_left_reg - 7'd1;
                if (fill_left_reg == 7'd1)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_LOAD:
            begin
                if (out_free)
                begin
                    do_tick    = 1'b1;
                    pop        = 1'b1;
                    state_next = BK_RUN;
                end
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase

        // One tick: emit the line level and step the bit timing.
        if (do_tick)
        begin
            out_valid_next            = 1'b1;
            out_data_next.line_level  = !in_gap_reg && (tick_reg < high_ticks);
            out_data_next.frame_start = (state_reg == BK_LOAD) && (ptr_reg == 7'd0);
            shift_next                = cur_word;
            if (tick_reg >= cfg.bit_top)
            begin
                tick_next = 16'd0;
                if (in_gap_reg)
                begin
                    if (gap_sum >= {1'b0, cfg.reset_slots})
                    begin
                        in_gap_next = 1'b0;
                        gap_next    = 10'd0;
                        ptr_next    = 7'd0;
                        bitpos_next = 5'd0;
                    end
                    else
                    begin
                        gap_next = gap_sum[9:0];
                    end
                end
                else
                begin
                    shift_next = {cur_word[WORD_W-2:0], 1'b0};
                    if (bit_sum >= 5'(BITS_PER_LED))
                    begin
                        bitpos_next = 5'd0;
                        if (ptr_sum >= {1'b0, leds})
                        begin
                            ptr_next    = 7'd0;
                            gap_next    = 10'd0;
                            in_gap_next = 1'b1;
                        end
                        else
                        begin
                            ptr_next = ptr_sum[6:0];
                        end
                    end
                    else
                    begin
                        bitpos_next = bit_sum;
                    end
                end
            end
            else
            begin
                tick_next = tick_reg + 16'd1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_addr_reg  <= '0;
            fill_left_reg <= '0;
            tick_reg      <= '0;
            bitpos_reg    <= '0;
            ptr_reg       <= '0;
            gap_reg       <= '0;
            in_gap_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            fill_left_reg <= fill_left_next;
            tick_reg      <= tick_next;
            bitpos_reg    <= bitpos_next;
            ptr_reg       <= ptr_next;
            gap_reg       <= gap_next;
            in_gap_reg    <= in_gap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        fill_pos_reg  <= fill_pos_next;
        fill_word_reg <= fill_word_next;
        shift_reg     <= shift_next;
        out_data_reg  <= out_data_next;
    end

    // Frame store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

endmodule

/* design/rgb_led_chain_pulse_serializer.sv */
// ----------------------------------------------------------------------------
// rgb_led_chain_pulse_serializer
// Frame store and one-wire pulse driver for a chain of addressable RGB LEDs.
// ----------------------------------------------------------------------------
// Requests are either color writes, which paint fill_count LEDs from
// led_index on, or timer ticks, each of which returns one line level. A tick
// is answered once the output is free; the first tick of every LED first
// passes through a load state, because the LED's word is fetched through
// the frame store's registered read port. A write fills its run one store
// entry per cycle through the single write port. A four-entry command queue
// lets the front keep accepting requests while the back end fills or the
// output is stalled. After reset the frame store is cleared, one entry per
// cycle, over all LED_SLOTS entries; no request is accepted during that pass,
// but configuration writes are taken.
// ----------------------------------------------------------------------------
module rgb_led_chain_pulse_serializer #(
    parameter int LED_SLOTS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  rlps_pkg::in_item_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output rlps_pkg::out_item_t                  out_data,
    input  logic                                 cfg_write,
    input  logic [rlps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rlps_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import rlps_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic push;
    cmd_t push_cmd;
    logic fifo_full;
    logic pop;
    logic head_valid;
    cmd_t head;
    logic clearing;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_BIT_TOP:     cfg_next.bit_top     = cfg_data;
                CFG_ZERO_HIGH:   cfg_next.zero_high   = cfg_data;
                CFG_ONE_HIGH:    cfg_next.one_high    = cfg_data;
                CFG_RESET_SLOTS: cfg_next.reset_slots = cfg_data[9:0];
                CFG_ACTIVE_LEDS: cfg_next.active_leds = cfg_data[6:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_top     <= 16'd125;
            cfg_reg.zero_high   <= 16'd42;
            cfg_reg.one_high    <= 16'd83;
            cfg_reg.reset_slots <= 10'd50;
            cfg_reg.active_leds <= 7'd64;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: accept and classify requests.
    rlps_front u_front (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .fifo_full (fifo_full),
        .clearing  (clearing),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // Command queue.
    rlps_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // Back end: frame store and pulse timing.
    rlps_back #(
        .LED_SLOTS (LED_SLOTS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .clearing   (clearing),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    // A frame starts at tick zero of a bit, so the line is high if both
    // high times are nonzero.
    a_frame_start_high: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.frame_start && (cfg_reg.zero_high != 16'd0)
         && (cfg_reg.one_high != 16'd0)) |-> out_data.line_level)
        else $error("frame start without a high line level");

    // No result can exist while the frame store is still being cleared.
    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !out_valid)
        else $error("result present during the clearing pass");

    // The queue is never popped when it holds nothing.
    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !head_valid) |-> 1'b0)
        else $error("command popped from an empty queue");

endmodule
